[rtl/dms_pkg.sv]
// Shared types, constants and tables for the delivery mission sequencer.
package dms_pkg;

	// CORDIC datapath widths: operands up to 2^49 plus gain, angle in 2^-16 rad
	localparam int CW = 52;
	localparam int ZW = 20;
	localparam int CORDIC_STEPS = 17;

	localparam logic signed [ZW-1:0] HALF_PI_U16 = ZW'(102944);
	localparam logic [32:0] TEN_SECONDS = 33'd655360;
	localparam logic [17:0] K_TENTH = 18'd133509;
	localparam logic [17:0] K_HUNDREDTH = 18'd13351;

	// config register indexes
	localparam logic [2:0] CFG_FLIGHT_ALT = 3'd0;
	localparam logic [2:0] CFG_ADV_PITCH = 3'd1;
	localparam logic [2:0] CFG_ARRIVE_TOL = 3'd2;
	localparam logic [2:0] CFG_LAND_TOL = 3'd3;
	localparam logic [2:0] CFG_COLL_TOL = 3'd4;
	localparam logic [2:0] CFG_BAL_GAIN = 3'd5;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_TAKEOFF = 3'd1,
		M_ROUTE = 3'd2,
		M_LAND = 3'd3,
		M_DELIVER = 3'd4,
		M_SHUTDOWN = 3'd5,
		M_COLLISION = 3'd6
	} mode_t;

	// one CORDIC job: which difference, which gain, which reference it feeds
	typedef enum logic [2:0] {
		J_TX = 3'd0,	// takeoff_x - x, 0.1 -> roll
		J_TY = 3'd1,	// takeoff_y - y, 0.1 -> pitch
		J_HEAD = 3'd2,	// atan2 to goal -> yaw
		J_GY = 3'd3,	// y - goal_y, 0.01 -> roll
		J_GX = 3'd4,	// x - goal_x, 0.01 -> pitch
		J_HY = 3'd5,	// home_y - y, 0.1 -> roll
		J_HX = 3'd6	// home_x - x, 0.1 -> pitch
	} job_t;

	typedef struct packed {
		logic capture;
		logic pre;
		logic diff;
		logic gain;
		logic cstart;
		logic scale;
		logic wr;
		logic sq;
		logic [1:0] sq_sel;
		logic fin;
		job_t job;
	} dms_cmd_t;

	typedef struct packed {
		logic is_new;
		mode_t mode;
		logic cdone;
		logic out_free;
	} dms_stat_t;

	function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0: v = ZW'(51472);
			5'd1: v = ZW'(30386);
			5'd2: v = ZW'(16055);
			5'd3: v = ZW'(8150);
			5'd4: v = ZW'(4091);
			5'd5: v = ZW'(2047);
			5'd6: v = ZW'(1024);
			5'd7: v = ZW'(512);
			5'd8: v = ZW'(256);
			5'd9: v = ZW'(128);
			5'd10: v = ZW'(64);
			5'd11: v = ZW'(32);
			5'd12: v = ZW'(16);
			5'd13: v = ZW'(8);
			5'd14: v = ZW'(4);
			5'd15: v = ZW'(2);
			5'd16: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/delivery_mission_sequencer.sv]
// Delivery drone mission sequencer: seven flight modes, attitude/altitude reference per tick.
// One input word at a time. A new-delivery word (tuser 1) is only accepted and latched and
// gives no output. A tick runs accept, latch and write-back plus the jobs of its mode. Each
// balance or heading term is one pass of the shared 17-step CORDIC: operand setup and result
// scaling, the iterations and hand-off, and on small operands a prescale loop. A heading on a
// zero vector skips the prescale and the iterations. So a tick runs three terms in takeoff,
// the heading plus the squares of both goal distances and of the arrival tolerance en route,
// two terms in landing and delivery, and none in idle, shutdown and collision hold. The
// finished word sits in an output register; write-back waits while an earlier word is still
// undelivered, and the next input is taken once it has been written.
module delivery_mission_sequencer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// time_now[31:0] pos_x[63:32] pos_y[95:64] pos_z[127:96] front_range[158:128]
	// down_range[189:159] target_x[221:190] target_y[253:222], rest zero
	input  logic [255:0] s_tdata,
	// cmd
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// ref_altitude[31:0] ref_roll[47:32] ref_pitch[63:48] ref_yaw[79:64] mode[82:80]
	output logic [87:0] m_tdata,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [30:0] cfg_data
);
	import dms_pkg::*;

	dms_cmd_t cmd;
	dms_stat_t stat;
	logic [31:0] ref_altitude;
	logic [15:0] ref_roll, ref_pitch, ref_yaw;
	logic [2:0] mode;

	dms_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	dms_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_cmd(s_tuser),
		.in_time(s_tdata[31:0]),
		.in_px(s_tdata[63:32]),
		.in_py(s_tdata[95:64]),
		.in_pz(s_tdata[127:96]),
		.in_front(s_tdata[158:128]),
		.in_down(s_tdata[189:159]),
		.in_tx(s_tdata[221:190]),
		.in_ty(s_tdata[253:222]),
		.cmd(cmd),
		.stat(stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.ref_altitude(ref_altitude),
		.ref_roll(ref_roll),
		.ref_pitch(ref_pitch),
		.ref_yaw(ref_yaw),
		.mode(mode)
	);

	assign m_tdata = {5'b0, mode, ref_yaw, ref_pitch, ref_roll, ref_altitude};

endmodule

[rtl/dms_cordic.sv]
// Iterative vectoring CORDIC: angle of (x, y) in 2^-16 rad.
module dms_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [dms_pkg::CW-1:0] y_in,
	input  logic signed [dms_pkg::CW-1:0] x_in,
	output logic done,
	output logic signed [dms_pkg::ZW-1:0] z_out
);
	import dms_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_NORM = 3'b010,
		C_ITER = 3'b100
	} cst_t;

	cst_t st_q;
	logic done_q;
	logic [4:0] i_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [CW-1:0] ax, ay, mmax;
	logic signed [CW-1:0] dx, dy;
	logic both_zero;

	assign ax = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
	assign ay = y_q[CW-1] ? CW'(-y_q) : CW'(y_q);
	assign mmax = (ax > ay) ? ax : ay;
	assign dx = x_q >>> i_q;
	assign dy = y_q >>> i_q;
	assign both_zero = (x_in == '0) && (y_in == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (start) begin
						if (both_zero) done_q <= 1'b1;
						else st_q <= C_NORM;
					end
				end
				C_NORM: begin
					if (mmax >= (CW'(1) << 40)) begin
						st_q <= C_ITER;
						i_q <= '0;
					end
				end
				C_ITER: begin
					i_q <= i_q + 5'd1;
					if (i_q == 5'(CORDIC_STEPS - 1)) begin
						st_q <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (start) begin
					z_q <= '0;
					x_q <= x_in;
					y_q <= y_in;
					// rotate left half plane into the right one
					if (x_in[CW-1]) begin
						if (!y_in[CW-1]) begin
							x_q <= y_in;
							y_q <= -x_in;
							z_q <= HALF_PI_U16;
						end else begin
							x_q <= -y_in;
							y_q <= x_in;
							z_q <= -HALF_PI_U16;
						end
					end
				end
			end
			C_NORM: begin
				if (mmax < (CW'(1) << 32)) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mmax < (CW'(1) << 40)) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ITER: begin
				if (y_q > 0) begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + atan_step(i_q);
				end else begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - atan_step(i_q);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign z_out = z_q;

endmodule

[rtl/dms_ctrl.sv]
// Controller: sequences capture, latches, CORDIC jobs, squares and write-back.
module dms_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  dms_pkg::dms_stat_t stat,
	output dms_pkg::dms_cmd_t cmd
);
	import dms_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_PRE = 10'b0000000010,
		S_JD = 10'b0000000100,
		S_JP = 10'b0000001000,
		S_JS = 10'b0000010000,
		S_JW = 10'b0000100000,
		S_JM = 10'b0001000000,
		S_JR = 10'b0010000000,
		S_SQ = 10'b0100000000,
		S_FIN = 10'b1000000000
	} st_t;

	st_t st_q;
	job_t job_q;
	logic [1:0] sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			job_q <= J_TX;
			sq_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (s_tvalid) st_q <= S_PRE;
				S_PRE: begin
					if (stat.is_new) begin
						st_q <= S_IDLE;
					end else begin
						st_q <= S_JD;
						case (stat.mode)
							M_TAKEOFF: job_q <= J_TX;
							M_ROUTE: job_q <= J_HEAD;
							M_LAND: job_q <= J_GY;
							M_DELIVER: job_q <= J_HY;
							default: st_q <= S_FIN;
						endcase
					end
				end
				S_JD: st_q <= S_JP;
				S_JP: st_q <= S_JS;
				S_JS: st_q <= S_JW;
				S_JW: if (stat.cdone) st_q <= S_JM;
				S_JM: st_q <= S_JR;
				S_JR: begin
					st_q <= S_JD;
					case (job_q)
						J_TX: job_q <= J_TY;
						J_TY: job_q <= J_HEAD;
						J_GY: job_q <= J_GX;
						J_HY: job_q <= J_HX;
						J_HEAD: begin
							if (stat.mode == M_ROUTE) begin
								st_q <= S_SQ;
								sq_q <= '0;
							end else begin
								st_q <= S_FIN;
							end
						end
						default: st_q <= S_FIN;
					endcase
				end
				S_SQ: begin
					sq_q <= sq_q + 2'd1;
					if (sq_q == 2'd2) st_q <= S_FIN;
				end
				S_FIN: if (stat.out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.job = job_q;
		cmd.sq_sel = sq_q;
		cmd.capture = (st_q == S_IDLE) && s_tvalid;
		cmd.pre = (st_q == S_PRE);
		cmd.diff = (st_q == S_JD);
		cmd.gain = (st_q == S_JP);
		cmd.cstart = (st_q == S_JS);
		cmd.scale = (st_q == S_JM);
		cmd.wr = (st_q == S_JR);
		cmd.sq = (st_q == S_SQ);
		cmd.fin = (st_q == S_FIN) && stat.out_free;
	end

	a_capture_pre: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (st_q == S_PRE) && !s_tready)
		else $error("accepted word did not enter the latch step");

	a_done_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_JW) && stat.cdone |=> (st_q == S_JM))
		else $error("CORDIC result not taken");

endmodule

[rtl/dms_dp.sv]
// Datapath: config, mission state, reference hold, job arithmetic, output word.
module dms_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [30:0] cfg_data,
	input  logic in_cmd,
	input  logic [31:0] in_time,
	input  logic [31:0] in_px,
	input  logic [31:0] in_py,
	input  logic [31:0] in_pz,
	input  logic [30:0] in_front,
	input  logic [30:0] in_down,
	input  logic [31:0] in_tx,
	input  logic [31:0] in_ty,
	input  dms_pkg::dms_cmd_t cmd,
	output dms_pkg::dms_stat_t stat,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] ref_altitude,
	output logic [15:0] ref_roll,
	output logic [15:0] ref_pitch,
	output logic [15:0] ref_yaw,
	output logic [2:0] mode
);
	import dms_pkg::*;

	// config
	logic [30:0] fa_q, at_q, lt_q, ct_q;
	logic signed [14:0] ap_q;
	logic [15:0] bg_q;

	// captured word
	logic new_q;
	logic [31:0] now_q;
	logic signed [31:0] px_q, py_q, pz_q, tgx_q, tgy_q;
	logic [30:0] front_q, down_q;

	// mission state
	mode_t mode_q;
	logic sp_q, dlv_q, tl_q, dl_q;
	logic signed [31:0] hx_q, hy_q, gx_q, gy_q, tkx_q, tky_q, dalt_q;
	logic [31:0] ds_q;
	logic signed [31:0] r0_q;
	logic signed [15:0] r1_q, r2_q, r3_q;

	// job arithmetic
	logic signed [32:0] d0_q, d1_q;
	logic signed [49:0] p_q;
	logic [36:0] prod_q;
	logic signed [15:0] hres_q;
	logic [63:0] sqx_q, sqy_q, tsq_q;

	// output word
	logic m_tvalid_q;
	logic [31:0] o_alt_q;
	logic [15:0] o_roll_q, o_pitch_q, o_yaw_q;
	logic [2:0] o_mode_q;

	function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q <= 31'd655360;
			ap_q <= '0;
			at_q <= 31'd65536;
			lt_q <= 31'd13107;
			ct_q <= 31'd65536;
			bg_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLIGHT_ALT: fa_q <= cfg_data;
				CFG_ADV_PITCH: ap_q <= $signed(cfg_data[14:0]);
				CFG_ARRIVE_TOL: at_q <= cfg_data;
				CFG_LAND_TOL: lt_q <= cfg_data;
				CFG_COLL_TOL: ct_q <= cfg_data;
				CFG_BAL_GAIN: bg_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_q <= in_cmd;
			now_q <= in_time;
			px_q <= in_px;
			py_q <= in_py;
			pz_q <= in_pz;
			front_q <= in_front;
			down_q <= in_down;
			tgx_q <= in_tx;
			tgy_q <= in_ty;
		end
	end

	// ---- CORDIC jobs ----
	logic cdone;
	logic signed [ZW-1:0] cz;
	logic signed [CW-1:0] cy, cx;
	logic [49:0] pmag;
	logic is_head;

	assign is_head = (cmd.job == J_HEAD);
	assign pmag = p_q[49] ? 50'(-p_q) : 50'(p_q);
	assign cy = is_head ? {{(CW-33){d0_q[32]}}, d0_q} : $signed({2'b00, pmag});
	assign cx = is_head ? {{(CW-33){d1_q[32]}}, d1_q} : (CW'(1) <<< 24);

	dms_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.cstart),
		.y_in(cy),
		.x_in(cx),
		.done(cdone),
		.z_out(cz)
	);

	logic [17:0] kgain;
	logic [18:0] a_cl;
	logic [ZW-1:0] zmag;
	logic [ZW-1:0] hround;
	logic [37:0] rsum;
	logic [15:0] bmag;
	logic signed [15:0] bres;
	logic [32:0] sq_op;

	always_comb begin
		case (cmd.job)
			J_GX, J_GY: kgain = K_HUNDREDTH;
			default: kgain = K_TENTH;
		endcase
	end

	assign a_cl = cz[ZW-1] ? '0 : cz[18:0];
	assign zmag = cz[ZW-1] ? ZW'(-cz) : ZW'(cz);
	assign hround = (zmag + ZW'(4)) >> 3;
	assign rsum = {1'b0, prod_q} + (38'd1 << 23);
	assign bmag = 16'(rsum[37:24]);
	assign bres = (p_q == '0) ? 16'sd0 : (p_q[49] ? $signed(-bmag) : $signed(bmag));

	always_comb begin
		case (cmd.sq_sel)
			2'd0: sq_op = d1_q[32] ? 33'(-d1_q) : 33'(d1_q);
			2'd1: sq_op = d0_q[32] ? 33'(-d0_q) : 33'(d0_q);
			default: sq_op = {2'b00, at_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			d1_q <= sub33(gx_q, px_q);
			case (cmd.job)
				J_TX: d0_q <= sub33(tkx_q, px_q);
				J_TY: d0_q <= sub33(tky_q, py_q);
				J_GY: d0_q <= sub33(py_q, gy_q);
				J_GX: d0_q <= sub33(px_q, gx_q);
				J_HY: d0_q <= sub33(hy_q, py_q);
				J_HX: d0_q <= sub33(hx_q, px_q);
				default: d0_q <= sub33(gy_q, py_q);
			endcase
		end
		if (cmd.gain) p_q <= 50'($signed({1'b0, bg_q}) * d0_q);
		if (cmd.scale) begin
			prod_q <= 37'(a_cl * kgain);
			hres_q <= cz[ZW-1] ? 16'(-hround) : 16'(hround);
		end
		if (cmd.sq) begin
			case (cmd.sq_sel)
				2'd0: sqx_q <= 64'(sq_op * sq_op);
				2'd1: sqy_q <= 64'(sq_op * sq_op);
				default: tsq_q <= 64'(sq_op * sq_op);
			endcase
		end
	end

	// ---- end of tick: mode transition and reference update ----
	logic signed [35:0] pz10, fa9;
	logic signed [32:0] dt;
	logic [64:0] sqsum;
	logic arrived, landed;
	mode_t nmode;
	logic signed [31:0] nr0;
	logic signed [15:0] nr1, nr2;

	assign pz10 = ($signed({{4{pz_q[31]}}, pz_q}) <<< 3) + ($signed({{4{pz_q[31]}}, pz_q}) <<< 1);
	assign fa9 = $signed({5'b0, fa_q}) + ($signed({5'b0, fa_q}) <<< 3);
	assign dt = $signed({1'b0, now_q}) - $signed({1'b0, ds_q});
	assign sqsum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign arrived = !sqsum[64] && (sqsum[63:0] < tsq_q);
	assign landed = down_q < lt_q;

	always_comb begin
		nmode = mode_q;
		nr0 = r0_q;
		nr1 = r1_q;
		nr2 = r2_q;
		case (mode_q)
			M_IDLE: if (sp_q) nmode = M_TAKEOFF;
			M_TAKEOFF: begin
				nr0 = $signed({1'b0, fa_q});
				if (pz10 >= fa9) nmode = M_ROUTE;
			end
			M_ROUTE: begin
				nr1 = '0;
				nr2 = 16'(ap_q);
				if (arrived) nmode = M_LAND;
				else if (front_q < ct_q) nmode = M_COLLISION;
			end
			M_LAND: begin
				nr0 = landed ? pz_q : 32'sd0;
				if (landed) nmode = dlv_q ? M_SHUTDOWN : M_DELIVER;
			end
			M_DELIVER: begin
				nr0 = dalt_q;
				if (dt > $signed(TEN_SECONDS)) nmode = M_TAKEOFF;
			end
			M_SHUTDOWN: begin
				nr1 = '0;
				nr2 = '0;
				nmode = M_IDLE;
			end
			M_COLLISION: if (front_q >= ct_q) nmode = M_ROUTE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			sp_q <= 1'b0;
			dlv_q <= 1'b0;
			tl_q <= 1'b0;
			dl_q <= 1'b0;
			hx_q <= '0;
			hy_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
			tkx_q <= '0;
			tky_q <= '0;
			ds_q <= '0;
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) m_tvalid_q <= 1'b0;
			if (cmd.pre) begin
				if (new_q) begin
					mode_q <= M_IDLE;
					dlv_q <= 1'b0;
					sp_q <= 1'b1;
					gx_q <= tgx_q;
					gy_q <= tgy_q;
				end else if (mode_q == M_TAKEOFF && !tl_q) begin
					tl_q <= 1'b1;
					tkx_q <= px_q;
					tky_q <= py_q;
				end else if (mode_q == M_DELIVER && !dl_q) begin
					dl_q <= 1'b1;
					ds_q <= now_q;
					dlv_q <= 1'b1;
					gx_q <= hx_q;
					gy_q <= hy_q;
					hx_q <= px_q;
					hy_q <= py_q;
				end
			end
			if (cmd.wr) begin
				case (cmd.job)
					J_TX, J_GY, J_HY: r1_q <= bres;
					J_TY, J_GX, J_HX: r2_q <= bres;
					default: r3_q <= hres_q;
				endcase
			end
			if (cmd.fin) begin
				mode_q <= nmode;
				r0_q <= nr0;
				r1_q <= nr1;
				r2_q <= nr2;
				m_tvalid_q <= 1'b1;
				case (mode_q)
					M_IDLE: begin
						if (sp_q) begin
							sp_q <= 1'b0;
							hx_q <= px_q;
							hy_q <= py_q;
						end
					end
					M_TAKEOFF: if (nmode == M_ROUTE) tl_q <= 1'b0;
					M_DELIVER: if (nmode == M_TAKEOFF) dl_q <= 1'b0;
					M_SHUTDOWN: begin
						sp_q <= 1'b0;
						dlv_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// dwell altitude is written before any read
	always_ff @(posedge clk) begin
		if (cmd.pre && !new_q && mode_q == M_DELIVER && !dl_q) dalt_q <= pz_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			o_alt_q <= nr0;
			o_roll_q <= nr1;
			o_pitch_q <= nr2;
			o_yaw_q <= r3_q;
			o_mode_q <= nmode;
		end
	end

	assign stat.is_new = new_q;
	assign stat.mode = mode_q;
	assign stat.cdone = cdone;
	assign stat.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign ref_altitude = o_alt_q;
	assign ref_roll = o_roll_q;
	assign ref_pitch = o_pitch_q;
	assign ref_yaw = o_yaw_q;
	assign mode = o_mode_q;

	a_word_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.fin))
		else $error("output word appeared without write-back");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!m_tvalid_q || m_tready))
		else $error("write-back over an undelivered word");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the delivery mission sequencer.
`timescale 1ns / 100ps

module testbench;
	import dms_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 5;
	localparam int WORDS_PER_PHASE = 340;
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam longint DWELL_LIMIT = 655360;
	localparam longint GAIN_TENTH = 133509;
	localparam longint GAIN_HUNDREDTH = 13351;
	localparam longint QUARTER_TURN = 102944;
	localparam longint ARC_STEP [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1};

	typedef struct {
		bit cmd;
		logic [31:0] tn, px, py, pz, tx, ty;
		logic [30:0] fr, dn;
	} word_t;

	typedef struct {
		logic [31:0] alt;
		logic [15:0] roll, pitch, yaw;
		logic [2:0] mode;
	} ref_word_t;

	typedef struct {
		word_t w;
		bit fixed;
		ref_word_t want;
	} step_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [87:0] m_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	delivery_mission_sequencer dut (.*);

	// predictor copy of configuration and mission state
	longint unsigned cfg_alt = 655360, cfg_arrive = 65536, cfg_land = 13107;
	longint unsigned cfg_coll = 65536, cfg_gain = 256;
	longint cfg_pitch = 0;
	mode_t mission = M_IDLE;
	bit pend = 0, delivered_f = 0, took_latched = 0, dwell_latched = 0;
	longint home_x = 0, home_y = 0, goal_x = 0, goal_y = 0, took_x = 0, took_y = 0;
	longint unsigned dwell_start = 0;
	longint dwell_alt = 0;
	longint refs [4] = '{0, 0, 0, 0};

	ref_word_t pending_refs [$];
	int errors = 0;
	int words_sent = 0, refs_seen = 0, new_jobs = 0;
	int mode_hits [8] = '{default: 0};
	bit no_idle = 0, hold_req = 0;
	longint unsigned clock_s = 0;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring CORDIC, angle in 2^-16 rad
	function automatic longint arc(longint y, longint x);
		longint z, t, dx, dy;
		longint unsigned m;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER_TURN;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER_TURN;
			end
		end
		m = magnitude(x) > magnitude(y) ? magnitude(x) : magnitude(y);
		while (m < (64'd1 << 40)) begin
			x = x * 2; y = y * 2; m = m << 1;
		end
		for (int i = 0; i < 17; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y > 0) begin
				x += dy; y -= dx; z += ARC_STEP[i];
			end else begin
				x -= dy; y += dx; z -= ARC_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic longint leveling(longint d, longint k);
		longint p, a;
		longint unsigned m, r;
		p = longint'(cfg_gain) * d;
		m = magnitude(p);
		if (m == 0)
			return 0;
		a = arc(longint'(m), 64'sd1 << 24);
		if (a < 0)
			a = 0;
		r = (longint'(a) * k + (64'd1 << 23)) >> 24;
		return p < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint bearing(longint px, longint py);
		longint a;
		longint unsigned r;
		a = arc(goal_y - py, goal_x - px);
		r = (magnitude(a) + 4) >> 3;
		return a < 0 ? -longint'(r) : longint'(r);
	endfunction

	// advance the mission by one accepted word; returns 1 when a reference word follows
	function automatic bit mission_step(input word_t w, output ref_word_t res);
		longint px, py, pz, sqx, sqy;
		longint unsigned now, sx, sy, sum;
		bit arrived;
		px = longint'(signed'(w.px));
		py = longint'(signed'(w.py));
		pz = longint'(signed'(w.pz));
		now = 64'(w.tn);
		if (w.cmd) begin
			mission = M_IDLE; delivered_f = 0;
			goal_x = longint'(signed'(w.tx)); goal_y = longint'(signed'(w.ty));
			pend = 1;
			return 0;
		end
		case (mission)
			M_IDLE: begin
				if (pend) begin
					pend = 0; mission = M_TAKEOFF; home_x = px; home_y = py;
				end
			end
			M_TAKEOFF: begin
				if (!took_latched) begin
					took_latched = 1; took_x = px; took_y = py;
				end
				refs[0] = longint'(cfg_alt);
				refs[1] = leveling(took_x - px, GAIN_TENTH);
				refs[2] = leveling(took_y - py, GAIN_TENTH);
				refs[3] = bearing(px, py);
				if (10 * pz >= 9 * longint'(cfg_alt)) begin
					mission = M_ROUTE; took_latched = 0;
				end
			end
			M_ROUTE: begin
				sx = magnitude(goal_x - px) * magnitude(goal_x - px);
				sy = magnitude(goal_y - py) * magnitude(goal_y - py);
				sum = sx + sy;
				arrived = sum >= sx && sum < cfg_arrive * cfg_arrive;
				refs[1] = 0;
				refs[2] = cfg_pitch;
				refs[3] = bearing(px, py);
				if (arrived)
					mission = M_LAND;
				else if (w.fr < cfg_coll)
					mission = M_COLLISION;
			end
			M_LAND: begin
				refs[0] = 0;
				refs[1] = leveling(py - goal_y, GAIN_HUNDREDTH);
				refs[2] = leveling(px - goal_x, GAIN_HUNDREDTH);
				if (w.dn < cfg_land) begin
					refs[0] = pz;
					mission = delivered_f ? M_SHUTDOWN : M_DELIVER;
				end
			end
			M_DELIVER: begin
				if (!dwell_latched) begin
					dwell_latched = 1; dwell_start = now; dwell_alt = pz;
					delivered_f = 1;
					goal_x = home_x; goal_y = home_y;
					home_x = px; home_y = py;
				end
				refs[0] = dwell_alt;
				refs[1] = leveling(home_y - py, GAIN_TENTH);
				refs[2] = leveling(home_x - px, GAIN_TENTH);
				if (longint'(now) - longint'(dwell_start) > DWELL_LIMIT) begin
					mission = M_TAKEOFF; dwell_latched = 0;
				end
			end
			M_SHUTDOWN: begin
				refs[1] = 0; refs[2] = 0;
				mission = M_IDLE; pend = 0; delivered_f = 0;
			end
			M_COLLISION: begin
				if (w.fr >= cfg_coll)
					mission = M_ROUTE;
			end
			default: ;
		endcase
		res.alt = refs[0][31:0];
		res.roll = refs[1][15:0];
		res.pitch = refs[2][15:0];
		res.yaw = refs[3][15:0];
		res.mode = mission;
		return 1;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_word(input word_t w, input bit fixed, input ref_word_t want);
		ref_word_t res;
		while (!no_idle && $urandom_range(99) < 9) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= w.cmd;
		s_tdata <= {2'b0, w.ty, w.tx, w.dn, w.fr, w.pz, w.py, w.px, w.tn};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (w.cmd)
			new_jobs++;
		if (mission_step(w, res)) begin
			mode_hits[res.mode]++;
			pending_refs.push_back(fixed ? want : res);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_FLIGHT_ALT: cfg_alt = 64'(val);
			CFG_ADV_PITCH: cfg_pitch = longint'(signed'(val[14:0]));
			CFG_ARRIVE_TOL: cfg_arrive = 64'(val);
			CFG_LAND_TOL: cfg_land = 64'(val);
			CFG_COLL_TOL: cfg_coll = 64'(val);
			CFG_BAL_GAIN: cfg_gain = 64'(val[15:0]);
			default: ;
		endcase
	endtask

	// wait until the block has drained, including a trailing new-delivery word
	task automatic drain();
		s_tvalid <= 0;
		wait (pending_refs.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int offset(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random word shaped by the current mission mode
	task automatic make_word(output word_t w);
		longint thr, span, v;
		w.cmd = 0;
		w.tx = $urandom; w.ty = $urandom;
		if ($urandom_range(99) < 10) begin
			w.cmd = $urandom_range(99) < 15;
			w.tn = $urandom; w.px = $urandom; w.py = $urandom; w.pz = $urandom;
			w.fr = 31'($urandom); w.dn = 31'($urandom);
			return;
		end
		if ((mission == M_IDLE && !pend && $urandom_range(99) < 60) ||
				$urandom_range(99) < 2) begin
			w.cmd = 1;
			if ($urandom_range(9) != 0) begin
				w.tx = 32'(goal_x + offset(1 << 22));
				w.ty = 32'(goal_y + offset(1 << 22));
			end
		end
		if (mission == M_DELIVER)
			clock_s = clock_s + $urandom_range(0, 4 << 16);
		else
			clock_s = clock_s + $urandom_range(0, 1 << 15);
		w.tn = $urandom_range(99) < 5 ? 32'(clock_s - $urandom_range(0, 8 << 16)) : 32'(clock_s);
		span = cfg_arrive >> 1;
		if (span > (1 << 22))
			span = 1 << 22;
		if (mission == M_ROUTE && $urandom_range(99) < 35 && span > 0) begin
			w.px = 32'(goal_x + offset(int'(span)));
			w.py = 32'(goal_y + offset(int'(span)));
		end else if ($urandom_range(9) == 0) begin
			w.px = $urandom; w.py = $urandom;
		end else begin
			w.px = 32'(goal_x + offset(1 << 20));
			w.py = 32'(goal_y + offset(1 << 20));
		end
		thr = (9 * longint'(cfg_alt) + 9) / 10;
		if (mission == M_TAKEOFF && $urandom_range(1))
			w.pz = 32'(thr + $urandom_range(0, 1000));
		else
			w.pz = 32'(thr - 1 - $urandom_range(0, 1 << 20));
		if (cfg_coll > 0 && $urandom_range(99) < (mission == M_COLLISION ? 50 : 15)) begin
			w.fr = 31'($urandom_range(0, 32'(cfg_coll - 1)));
		end else begin
			v = longint'(cfg_coll) + $urandom_range(0, 1 << 20);
			w.fr = v > 64'h7FFFFFFF ? 31'h7FFFFFFF : 31'(v);
		end
		if (cfg_land > 0 && $urandom_range(99) < (mission == M_LAND ? 40 : 10))
			w.dn = 31'($urandom_range(0, 32'(cfg_land - 1)));
		else
			w.dn = 31'($urandom);
	endtask

	function automatic word_t tick(logic [31:0] tn, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [30:0] fr, logic [30:0] dn);
		word_t w;
		w.cmd = 0; w.tn = tn; w.px = px; w.py = py; w.pz = pz;
		w.fr = fr; w.dn = dn; w.tx = '0; w.ty = '0;
		return w;
	endfunction

	function automatic word_t job(logic [31:0] tx, logic [31:0] ty);
		word_t w;
		w = tick('0, '0, '0, '0, '0, '0);
		w.cmd = 1; w.tx = tx; w.ty = ty;
		return w;
	endfunction

	// reference word receiver and checker
	initial begin
		ref_word_t e;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				refs_seen++;
				if (pending_refs.size() == 0) begin
					report($sformatf("unexpected word %h", m_tdata));
				end else begin
					e = pending_refs.pop_front();
					if (m_tdata[31:0] !== e.alt)
						report($sformatf("altitude %h, want %h", m_tdata[31:0], e.alt));
					if (m_tdata[47:32] !== e.roll)
						report($sformatf("roll %h, want %h", m_tdata[47:32], e.roll));
					if (m_tdata[63:48] !== e.pitch)
						report($sformatf("pitch %h, want %h", m_tdata[63:48], e.pitch));
					if (m_tdata[79:64] !== e.yaw)
						report($sformatf("yaw %h, want %h", m_tdata[79:64], e.yaw));
					if (m_tdata[82:80] !== e.mode)
						report($sformatf("mode %0d, want %0d", m_tdata[82:80], e.mode));
				end
			end
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= 9;
			end
		end
	end

	// stall watchdog
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else if (++quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", quiet);
				$display("** delivery_mission_sequencer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		step_t steps [$];
		step_t st;
		ref_word_t z, z_to;
		word_t w;
		z = '{alt: '0, roll: '0, pitch: '0, yaw: '0, mode: M_IDLE};
		z_to = z;
		z_to.mode = M_TAKEOFF;
		// directed walk through a full mission, extremes and corner cases
		steps.push_back('{tick('0, '0, '0, '0, '1, '1), 1, z});
		steps.push_back('{job(32'h7FFFFFFF, 32'h80000000), 0, z});
		steps.push_back('{tick('0, '0, '0, '0, '1, '1), 1, z_to});
		steps.push_back('{tick('0, 32'h80000000, 32'h7FFFFFFF, '0, '1, '1), 0, z});
		steps.push_back('{tick('0, '0, '0, 32'h7FFFFFFF, '1, '1), 0, z});
		steps.push_back('{tick('0, '0, '0, 32'h80000000, '0, '1), 0, z});
		steps.push_back('{tick('0, '0, '0, '0, '1, '1), 0, z});
		steps.push_back('{tick('0, 32'h7FFFFFFF, 32'h80000000, '0, '1, '1), 0, z});
		steps.push_back('{tick('0, '1, '1, '0, '1, '1), 0, z});
		steps.push_back('{tick('0, 32'h7FFFFFF0, 32'h80000010, 32'h12345, '1, '0), 0, z});
		steps.push_back('{tick(32'h00100000, '0, '0, '0, '0, '0), 0, z});
		// time running backwards keeps the dwell
		steps.push_back('{tick('0, 32'h100, 32'hFFFFFF00, '0, '0, '0), 0, z});
		// new delivery in the middle of a dwell
		steps.push_back('{job('0, '0), 0, z});
		steps.push_back('{tick(32'h00110000, 32'd100, -32'sd100, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h00110000, '0, '0, 32'h7FFFFFFF, '1, '1), 0, z});
		steps.push_back('{tick(32'h00110000, '0, '0, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h00110000, '0, '0, 32'h400, '1, '0), 0, z});
		// dwell ends only once strictly more than ten seconds have passed
		steps.push_back('{tick(32'h001A0000, '0, '0, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h001A0001, '0, '0, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h001B0000, 32'h10000, '0, 32'h7FFFFFFF, '1, '1), 0, z});
		steps.push_back('{tick(32'h001B0000, '0, '0, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h001B0000, '0, '0, '0, '1, '0), 0, z});
		steps.push_back('{tick('0, 32'h5000, 32'h6000, '0, '1, '1), 0, z});
		steps.push_back('{tick(32'h000A0001, 32'h5000, 32'h6000, '0, '1, '1), 0, z});
		steps.push_back('{tick('1, '1, '1, '1, '1, '1), 0, z});

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (steps[i]) begin
			st = steps[i];
			send_word(st.w, st.fixed, st.want);
		end
		clock_s = 64'h00200000;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: begin
						write_reg(CFG_FLIGHT_ALT, 31'h7FFFFFFF);
						write_reg(CFG_ADV_PITCH, 31'(15'sd12868));
						write_reg(CFG_ARRIVE_TOL, 31'h7FFFFFFF);
						write_reg(CFG_LAND_TOL, 31'h7FFFFFFF);
						write_reg(CFG_COLL_TOL, 31'h7FFFFFFF);
						write_reg(CFG_BAL_GAIN, 31'hFFFF);
						write_reg(CFG_UNUSED, 31'($urandom));
					end
					2: begin
						write_reg(CFG_FLIGHT_ALT, '0);
						write_reg(CFG_ADV_PITCH, 31'(-15'sd12868));
						write_reg(CFG_ARRIVE_TOL, '0);
						write_reg(CFG_LAND_TOL, '0);
						write_reg(CFG_COLL_TOL, '0);
						write_reg(CFG_BAL_GAIN, '0);
					end
					default: begin
						write_reg(CFG_FLIGHT_ALT, 31'($urandom_range(0, 1 << 24)));
						write_reg(CFG_ADV_PITCH, 31'($urandom_range(0, 25736) - 12868));
						write_reg(CFG_ARRIVE_TOL, 31'($urandom_range(1 << 12, 1 << 18)));
						write_reg(CFG_LAND_TOL, 31'($urandom_range(1, 1 << 16)));
						write_reg(CFG_COLL_TOL, 31'($urandom_range(1, 1 << 17)));
						write_reg(CFG_BAL_GAIN, 31'($urandom_range(0, 65535)));
						write_reg(CFG_UNUSED, 31'($urandom));
					end
				endcase
				cfg_we <= 0;
			end
			no_idle = (ph == 3);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (ph == 1 && n == 100)
					hold_req = 1;
				if (ph == 3 && n == 150) begin
					s_tvalid <= 0;
					wait (pending_refs.size() == 0);
					@(posedge clk);
				end
				make_word(w);
				send_word(w, 0, z);
			end
		end
		drain();
		$display("%0d words in (%0d new deliveries), %0d reference words checked",
			words_sent, new_jobs, refs_seen);
		$display("mode after tick: idle %0d takeoff %0d route %0d land %0d dwell %0d off %0d hold %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
			mode_hits[5], mode_hits[6]);
		if (errors == 0)
			$display("** delivery_mission_sequencer: PASSED **");
		else
			$display("** delivery_mission_sequencer: FAILED **");
		$finish;
	end

endmodule
